// ===== src/sace_pkg.sv =====
// ---------------------------------------------------------------------------
// sace_pkg: shared constants and types
// Geometry, register indexes, item kinds, hash constants and the structs
// that run between the controller and its storage blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package sace_pkg;

  // Geometry. SETS and CHANNELS are powers of two, SETS at least 2.
  localparam int WAYS     = 8;
  localparam int SETS     = 64;
  localparam int CHANNELS = 1024;

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SCAN_W = $clog2(WAYS + 1);
  localparam int SET_W  = $clog2(SETS);
  localparam int CH_W   = $clog2(CHANNELS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASHED_MAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PF_DEPTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_CYCLES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_CYCLES = 3'd4;

  // Request kinds
  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_SPIKE  = 2'd1;
  localparam logic [1:0] KIND_STEP   = 2'd2;

  // Hash multipliers
  localparam logic [63:0] HASH_C1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_C2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] HASH_CHAN = 64'h9e3779b97f4a7c15;

  localparam logic [15:0] SCORE_MAX = 16'hFFFF;
  localparam logic [31:0] AGE_MAX   = 32'hFFFFFFFF;

  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [31:0] age;
    logic [15:0] chan;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic            rd_en;
    logic            rd_before;
    logic            wr_en;
    logic            swap;
    logic            clr;
    logic [CH_W-1:0] addr;
    logic [15:0]     wdata;
  } score_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] rdata;
  } score_sts_t;

endpackage

`default_nettype wire

// ===== src/sace_in_if.sv =====
// ---------------------------------------------------------------------------
// sace_in_if: request channel
// Valid/ready channel carrying one access, spike or step request.
// ---------------------------------------------------------------------------
`default_nettype none

interface sace_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] tile;
  logic [15:0] channel;
  logic [11:0] kernel_row;
  logic [11:0] kernel_col;
  logic [15:0] step;
  logic        force_lru;

  modport source (output valid, kind, tile, channel, kernel_row, kernel_col, step,
                  force_lru, input ready);
  modport sink (input valid, kind, tile, channel, kernel_row, kernel_col, step,
                force_lru, output ready);
endinterface

`default_nettype wire

// ===== src/sace_out_if.sv =====
// ---------------------------------------------------------------------------
// sace_out_if: result channel
// Valid/ready channel carrying the outcome of one access.
// ---------------------------------------------------------------------------
`default_nettype none

interface sace_out_if;
  logic       valid;
  logic       ready;
  logic       line_miss;
  logic [9:0] line_cycles;
  logic [2:0] prefetch_count;
  logic [2:0] prefetch_fills;

  modport source (output valid, line_miss, line_cycles, prefetch_count,
                  prefetch_fills, input ready);
  modport sink (input valid, line_miss, line_cycles, prefetch_count,
                prefetch_fills, output ready);
endinterface

`default_nettype wire

// ===== src/sace_hash.sv =====
// ---------------------------------------------------------------------------
// sace_hash: multi-cycle set hash
// Mixes key and channel with one shared 32x32 multiplier, 64-bit products
// built from partial products; the set index is valid once done is raised.
// ---------------------------------------------------------------------------
`default_nettype none

module sace_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [63:0]               key,
  input  logic [15:0]               chan,
  output logic                      done,
  output logic [sace_pkg::SET_W-1:0] set_idx
);
  import sace_pkg::*;

  localparam logic [3:0] PH_LAST = 4'd10;

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] chan_q;
  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] mult_a;
  logic [31:0] mult_b;
  logic [63:0] acc_hi;

  function automatic logic [63:0] fold33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

  assign acc_hi  = acc + {prod[31:0], 32'd0};
  assign set_idx = x[SET_W-1:0];

  always_comb begin
    case (cnt)
      4'd0:    begin mult_a = {16'd0, chan_q}; mult_b = HASH_CHAN[31:0];  end
      4'd1:    begin mult_a = {16'd0, chan_q}; mult_b = HASH_CHAN[63:32]; end
      4'd3:    begin mult_a = x[31:0];  mult_b = HASH_C1[31:0];  end
      4'd4:    begin mult_a = x[63:32]; mult_b = HASH_C1[31:0];  end
      4'd5:    begin mult_a = x[31:0];  mult_b = HASH_C1[63:32]; end
      4'd7:    begin mult_a = x[31:0];  mult_b = HASH_C2[31:0];  end
      4'd8:    begin mult_a = x[63:32]; mult_b = HASH_C2[31:0];  end
      4'd9:    begin mult_a = x[31:0];  mult_b = HASH_C2[63:32]; end
      default: begin mult_a = 32'd0;    mult_b = 32'd0;          end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= busy && (cnt == PH_LAST);
      if (start) begin
        busy   <= 1'b1;
        cnt    <= 4'd0;
        chan_q <= chan;
        x      <= key ^ (key >> 11);
      end else if (busy) begin
        prod <= {32'd0, mult_a} * {32'd0, mult_b};
        cnt  <= cnt + 4'd1;
        case (cnt) inside
          4'd1, 4'd4, 4'd8: acc <= prod;
          4'd5, 4'd9:       acc <= acc_hi;
          4'd2:             x   <= fold33(x ^ acc_hi);
          4'd6, 4'd10:      x   <= fold33(acc_hi);
          default:          ;
        endcase
        if (cnt == PH_LAST) busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sace_line_store.sv =====
// ---------------------------------------------------------------------------
// sace_line_store: set memory
// One row per set holding every way; registered read, per-row valid bits
// so an unwritten row reads as all ways invalid with zero fields.
// ---------------------------------------------------------------------------
`default_nettype none

module sace_line_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [sace_pkg::SET_W-1:0] rd_addr,
  output sace_pkg::row_t             rd_row,
  input  logic                       wr_en,
  input  logic [sace_pkg::SET_W-1:0] wr_addr,
  input  sace_pkg::row_t             wr_row
);
  import sace_pkg::*;

  row_t            mem [SETS];
  logic [SETS-1:0] row_valid;
  row_t            q;
  logic            q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_valid   <= 1'b0;
    end else begin
      if (wr_en) row_valid[wr_addr] <= 1'b1;
      if (rd_en) q_valid <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    if (rd_en) q <= mem[rd_addr];
  end

  assign rd_row = q_valid ? q : '0;

endmodule

`default_nettype wire

// ===== src/sace_score_store.sv =====
// ---------------------------------------------------------------------------
// sace_score_store: spike score banks
// Two banks swap roles between current and previous step; a sweep clears
// one or both banks, and both after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module sace_score_store (
  input  logic                   clk,
  input  logic                   rst,
  input  sace_pkg::score_cmd_t   cmd,
  output sace_pkg::score_sts_t   sts
);
  import sace_pkg::*;

  logic [15:0]     bank0 [CHANNELS];
  logic [15:0]     bank1 [CHANNELS];
  logic            sel;
  logic [1:0]      clr_mask;
  logic [CH_W-1:0] sweep;
  logic [15:0]     q0;
  logic [15:0]     q1;
  logic            rsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel      <= 1'b0;
      clr_mask <= 2'b11;
      sweep    <= '0;
    end else if (clr_mask != 2'b00) begin
      sweep <= sweep + 1'b1;
      if (sweep == CH_W'(CHANNELS - 1)) clr_mask <= 2'b00;
    end else if (cmd.clr) begin
      sweep <= '0;
      if (cmd.swap) begin
        // the old previous-step bank becomes current and starts empty
        sel      <= ~sel;
        clr_mask <= sel ? 2'b01 : 2'b10;
      end else begin
        clr_mask <= 2'b11;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_mask[0]) bank0[sweep] <= 16'd0;
    else if (cmd.wr_en && !sel) bank0[cmd.addr] <= cmd.wdata;
    if (clr_mask[1]) bank1[sweep] <= 16'd0;
    else if (cmd.wr_en && sel) bank1[cmd.addr] <= cmd.wdata;
    if (cmd.rd_en) begin
      q0   <= bank0[cmd.addr];
      q1   <= bank1[cmd.addr];
      rsel <= cmd.rd_before ? ~sel : sel;
    end
  end

  assign sts.busy  = (clr_mask != 2'b00);
  assign sts.rdata = rsel ? q1 : q0;

endmodule

`default_nettype wire

// ===== src/set_assoc_cache_scoreboard_evict_unit.sv =====
// ---------------------------------------------------------------------------
// set_assoc_cache_scoreboard_evict_unit: scoreboard-steered line cache
// Set-associative tag store with LRU or spike-score victim choice and
// next-channel prefetch.
// ---------------------------------------------------------------------------
// Requests are handled one at a time. An access serves the demand line and,
// after a demand miss, up to the configured prefetch depth of next-channel
// lines; each line served passes through MAP, RD, CMP, WR and NEXT, also
// through the shared-multiplier hash with hashed mapping, and through a
// victim scan of scores and ages when a full set has no free way (one score
// memory read per way). The DONE state then posts the result, waiting while
// the previous result is still pending. An in-range spike holds the unit for
// a score read, then an increment and write back. A step holds it in STEP,
// and when it moves or resets the scoreboard the score banks are swept, one
// entry per channel, during which no request is taken. The same sweep of both
// banks runs after reset. A finished result waits in an output register; the
// next request is taken as soon as the unit is idle, even while that result
// is pending.
// Configuration writes are taken at any time but must only change while no
// request is in progress.
// ---------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_scoreboard_evict_unit (
  input  logic                            clk,
  input  logic                            rst,
  sace_in_if.sink                         req,
  sace_out_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [sace_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sace_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sace_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SPIKE_RD = 4'd1;
  localparam logic [3:0] ST_SPIKE_WR = 4'd2;
  localparam logic [3:0] ST_STEP     = 4'd3;
  localparam logic [3:0] ST_MAP      = 4'd4;
  localparam logic [3:0] ST_HASH     = 4'd5;
  localparam logic [3:0] ST_RD       = 4'd6;
  localparam logic [3:0] ST_CMP      = 4'd7;
  localparam logic [3:0] ST_SCAN     = 4'd8;
  localparam logic [3:0] ST_WR       = 4'd9;
  localparam logic [3:0] ST_NEXT     = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  // configuration
  logic       lru_mode;
  logic       hashed_map;
  logic [2:0] pf_depth;
  logic [7:0] hit_cycles;
  logic [9:0] miss_cycles;

  // step tracking
  logic [15:0] cur_step;
  logic        step_seen;
  logic        lru_only;

  // request in progress
  logic [3:0]  state;
  logic [23:0] tile_q;
  logic [15:0] chan_base;
  logic [15:0] cur_chan;
  logic [11:0] kh_q;
  logic [11:0] kw_q;
  logic [15:0] step_q;
  logic        use_lru_q;
  logic [3:0]  pf_d;
  logic [2:0]  pf_n;
  logic [2:0]  pf_m;
  logic        dmd_miss;
  logic        miss_cur;
  logic [SET_W-1:0] set_idx;
  logic [63:0] tag;
  logic [WAY_W-1:0] vic;

  // victim scan pipeline
  logic [SCAN_W-1:0] scan_k;
  logic              scan_v;
  logic [WAY_W-1:0]  way_q;
  logic [31:0]       age_q;
  logic              chok_q;
  logic [15:0]       best_sc;
  logic [31:0]       best_age;

  // result register
  logic       out_valid;
  logic       out_miss;
  logic [9:0] out_cycles;
  logic [2:0] out_pf_n;
  logic [2:0] out_pf_m;

  // datapath
  logic [63:0]      key;
  row_t             line_row;
  row_t             new_row;
  logic             hit_any;
  logic             inv_any;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] kidx;
  logic [15:0]      sc_eff;
  logic             take;
  logic [3:0]       pf_dn;
  logic [16:0]      chan_sum;
  logic             req_fire;
  logic             spike_ok;
  logic             hash_start;
  logic             hash_done;
  logic [SET_W-1:0] hash_set;
  logic             step_same;
  logic             step_keep;
  logic             step_adv;
  score_cmd_t       sc_cmd;
  score_sts_t       sc_sts;

  assign key      = {tile_q, cur_chan, kh_q, kw_q};
  assign kidx     = scan_k[WAY_W-1:0];
  assign req.ready = (state == ST_IDLE) && !sc_sts.busy;
  assign req_fire = req.valid && req.ready;
  assign spike_ok = ({1'b0, req.channel} < 17'(CHANNELS));
  assign hash_start = (state == ST_MAP) && hashed_map;
  assign pf_dn    = pf_d + 4'd1;
  assign chan_sum = {1'b0, chan_base} + {13'd0, pf_dn};

  // step transitions
  assign step_same = step_seen && (step_q == cur_step);
  assign step_keep = !step_seen && (step_q == 16'd0);
  assign step_adv  = ({1'b0, step_q} ==
                      (step_seen ? ({1'b0, cur_step} + 17'd1) : 17'd1));

  assign rsp.valid          = out_valid;
  assign rsp.line_miss      = out_miss;
  assign rsp.line_cycles    = out_cycles;
  assign rsp.prefetch_count = out_pf_n;
  assign rsp.prefetch_fills = out_pf_m;

  sace_hash u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (hash_start),
    .key     (key),
    .chan    (cur_chan),
    .done    (hash_done),
    .set_idx (hash_set)
  );

  sace_line_store u_lines (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == ST_RD),
    .rd_addr (set_idx),
    .rd_row  (line_row),
    .wr_en   (state == ST_WR),
    .wr_addr (set_idx),
    .wr_row  (new_row)
  );

  sace_score_store u_scores (
    .clk (clk),
    .rst (rst),
    .cmd (sc_cmd),
    .sts (sc_sts)
  );

  // Hit and first-invalid search across the row (lowest way wins).
  always_comb begin
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (line_row[i].valid && (line_row[i].tag == tag)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!line_row[i].valid) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(i);
      end
    end
  end

  // Touch: age every way (saturating), zero the used way, fill on a miss.
  always_comb begin
    new_row = line_row;
    for (int i = 0; i < WAYS; i++) begin
      if (line_row[i].age != AGE_MAX) new_row[i].age = line_row[i].age + 32'd1;
    end
    new_row[vic].age = 32'd0;
    if (miss_cur) begin
      new_row[vic].valid = 1'b1;
      new_row[vic].tag   = tag;
      new_row[vic].chan  = cur_chan;
    end
  end

  // Victim compare: score of zero stands for LRU mode and unknown channels,
  // so one comparator covers both policies; older way wins a tie.
  assign sc_eff = (use_lru_q || lru_only || !chok_q) ? 16'd0 : sc_sts.rdata;
  assign take   = (way_q == '0) || (sc_eff < best_sc) ||
                  ((sc_eff == best_sc) && (age_q > best_age));

  // Score memory requests
  always_comb begin
    sc_cmd = '0;
    unique case (state)
      ST_SPIKE_RD: begin
        sc_cmd.rd_en = 1'b1;
        sc_cmd.addr  = cur_chan[CH_W-1:0];
      end
      ST_SPIKE_WR: begin
        sc_cmd.wr_en = 1'b1;
        sc_cmd.addr  = cur_chan[CH_W-1:0];
        sc_cmd.wdata = (sc_sts.rdata == SCORE_MAX) ? sc_sts.rdata
                                                   : sc_sts.rdata + 16'd1;
      end
      ST_STEP: begin
        if (!step_same && !step_keep) begin
          sc_cmd.clr  = 1'b1;
          sc_cmd.swap = step_adv;
        end
      end
      ST_SCAN: begin
        if (scan_k < SCAN_W'(WAYS)) begin
          sc_cmd.rd_en     = 1'b1;
          sc_cmd.rd_before = 1'b1;
          sc_cmd.addr      = line_row[kidx].chan[CH_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lru_mode        <= 1'b0;
      hashed_map      <= 1'b1;
      pf_depth        <= 3'd0;
      hit_cycles      <= 8'd1;
      miss_cycles     <= 10'd20;
      cur_step        <= 16'd0;
      step_seen       <= 1'b0;
      lru_only        <= 1'b1;
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      scan_v          <= 1'b0;
      scan_k          <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_LRU_MODE:    lru_mode    <= cfg_data[0];
          CFG_HASHED_MAP:  hashed_map  <= cfg_data[0];
          CFG_PF_DEPTH:    pf_depth    <= cfg_data[2:0];
          CFG_HIT_CYCLES:  hit_cycles  <= cfg_data[7:0];
          CFG_MISS_CYCLES: miss_cycles <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once taken; the completion state reloads it itself
      if (out_valid && rsp.ready && (state != ST_DONE)) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            case (req.kind)
              KIND_ACCESS: begin
                tile_q      <= req.tile;
                chan_base   <= req.channel;
                cur_chan    <= req.channel;
                kh_q        <= req.kernel_row;
                kw_q        <= req.kernel_col;
                use_lru_q   <= req.force_lru || lru_mode;
                pf_d        <= 4'd0;
                pf_n        <= 3'd0;
                pf_m        <= 3'd0;
                dmd_miss    <= 1'b0;
                if (!step_seen) begin
                  cur_step  <= 16'd0;
                  step_seen <= 1'b1;
                end
                state <= ST_MAP;
              end
              KIND_SPIKE: begin
                cur_chan <= req.channel;
                if (spike_ok) state <= ST_SPIKE_RD;
              end
              KIND_STEP: begin
                step_q <= req.step;
                state  <= ST_STEP;
              end
              default: ;
            endcase
          end
        end
        ST_SPIKE_RD: state <= ST_SPIKE_WR;
        ST_SPIKE_WR: state <= ST_IDLE;
        ST_STEP: begin
          if (!step_same) begin
            lru_only  <= (step_q == 16'd0);
            cur_step  <= step_q;
            step_seen <= 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_MAP: begin
          if (hashed_map) begin
            tag   <= key;
            state <= ST_HASH;
          end else begin
            set_idx <= key[SET_W-1:0];
            tag     <= key >> SET_W;
            state   <= ST_RD;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            set_idx <= hash_set;
            state   <= ST_RD;
          end
        end
        ST_RD: state <= ST_CMP;
        ST_CMP: begin
          if (hit_any) begin
            vic      <= hit_way;
            miss_cur <= 1'b0;
            state    <= ST_WR;
          end else if (inv_any) begin
            vic      <= inv_way;
            miss_cur <= 1'b1;
            state    <= ST_WR;
          end else begin
            miss_cur <= 1'b1;
            scan_k   <= '0;
            scan_v   <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue way k, compare way k-1 as its score returns
          if (scan_k < SCAN_W'(WAYS)) begin
            way_q  <= kidx;
            age_q  <= line_row[kidx].age;
            chok_q <= ({1'b0, line_row[kidx].chan} < 17'(CHANNELS));
            scan_v <= 1'b1;
            scan_k <= scan_k + 1'b1;
          end else begin
            scan_v <= 1'b0;
            state  <= ST_WR;
          end
          if (scan_v && take) begin
            best_sc  <= sc_eff;
            best_age <= age_q;
            vic      <= way_q;
          end
        end
        ST_WR: begin
          if (pf_d == 4'd0) dmd_miss <= miss_cur;
          else if (miss_cur) pf_m <= pf_m + 3'd1;
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (dmd_miss && (pf_dn <= {1'b0, pf_depth}) && !chan_sum[16]) begin
            pf_d     <= pf_dn;
            cur_chan <= chan_sum[15:0];
            pf_n     <= pf_n + 3'd1;
            state    <= ST_MAP;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_miss   <= dmd_miss;
            out_cycles <= dmd_miss ? miss_cycles : {2'd0, hit_cycles};
            out_pf_n   <= pf_n;
            out_pf_m   <= pf_m;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A spike increment always follows its own score read.
  a_spike_rmw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPIKE_WR) |-> ($past(state) == ST_SPIKE_RD))
    else $error("spike write without preceding read");

  // A new result appears only out of the completion state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == ST_DONE))
    else $error("result loaded outside completion");

  // Filled prefetch lines never exceed issued prefetch lines.
  a_pf_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.prefetch_fills <= rsp.prefetch_count))
    else $error("prefetch fills exceed prefetch count");

  // No line work overlaps a score bank sweep.
  a_no_sweep_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR || state == ST_SCAN) |-> !sc_sts.busy)
    else $error("line access during score sweep");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: set_assoc_cache_scoreboard_evict_unit
// Drives access, spike and step requests with random idling on both sides,
// predicts every access outcome with a cycle-free model of the tag store,
// LRU ages and spike scoreboard, and checks each outcome in order.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sace_pkg::*;

  // kind code that the unit must drop without a result
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // longest quiet stretch: score sweep plus a full prefetch burst, with margin
  localparam int WATCHDOG_LIMIT = 20000;
  // cycles to let a resultless request (step sweep) finish before a config write
  localparam int SETTLE_CYCLES = 1200;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct {
    logic [1:0]  kind;
    logic [23:0] tile;
    logic [15:0] channel;
    logic [11:0] kernel_row;
    logic [11:0] kernel_col;
    logic [15:0] step;
    logic        force_lru;
  } request_t;

  typedef struct {
    logic       line_miss;
    logic [9:0] line_cycles;
    logic [2:0] prefetch_count;
    logic [2:0] prefetch_fills;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sace_in_if  req();
  sace_out_if rsp();

  set_assoc_cache_scoreboard_evict_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req.sink),
    .rsp       (rsp.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // -------------------------------------------------------------------------
  // Cache model: shadow registers, tag store and scoreboard
  // -------------------------------------------------------------------------
  logic        m_lru_policy;
  logic        m_hashed;
  logic [2:0]  m_pf_depth;
  logic [7:0]  m_hit_cyc;
  logic [9:0]  m_miss_cyc;

  logic [63:0] way_tag   [SETS*WAYS];
  logic        way_valid [SETS*WAYS];
  logic [31:0] way_age   [SETS*WAYS];
  logic [15:0] way_chan  [SETS*WAYS];
  logic [15:0] spikes_now  [CHANNELS];
  logic [15:0] spikes_prev [CHANNELS];
  logic [15:0] cur_step;
  logic        step_started;
  logic        lru_step;

  outcome_t expected_q[$];
  int  fails = 0;
  int  mismatches = 0;
  bit  quiet = 1'b0;   // no idling in the closing part of the run

  function automatic logic [31:0] line_hash(logic [63:0] key, logic [15:0] chan);
    logic [63:0] x;
    x = key ^ (key >> 11) ^ ({48'd0, chan} * HASH_CHAN);
    x ^= x >> 33; x = x * HASH_C1;
    x ^= x >> 33; x = x * HASH_C2;
    x ^= x >> 33;
    return x[31:0];
  endfunction

  function automatic void age_set(int base, int way);
    for (int i = 0; i < WAYS; i++)
      if (way_age[base+i] != AGE_MAX) way_age[base+i]++;
    way_age[base+way] = '0;
  endfunction

  function automatic int oldest_way(int base);
    int best;
    best = 0;
    for (int i = 1; i < WAYS; i++)
      if (way_age[base+i] > way_age[base+best]) best = i;
    return best;
  endfunction

  // lowest previous-step score; oldest way breaks a tie
  function automatic int coldest_way(int base);
    int best;
    logic [31:0] low, sc;
    best = 0;
    low = 32'hFFFFFFFF;
    for (int i = 0; i < WAYS; i++) begin
      sc = (way_chan[base+i] < CHANNELS) ? {16'd0, spikes_prev[way_chan[base+i]]} : 32'd0;
      if (sc < low || (sc == low && way_age[base+i] > way_age[base+best])) begin
        low = sc;
        best = i;
      end
    end
    return best;
  endfunction

  // look up one line, fill on a miss; returns 1 on a miss
  function automatic bit lookup_line(logic [23:0] tile, logic [15:0] chan,
                                     logic [11:0] kh, logic [11:0] kw, bit use_lru);
    logic [63:0] key, tag;
    int set_idx, base, victim;
    bit have_free;
    key = {tile, chan, kh, kw};
    if (m_hashed) begin
      set_idx = line_hash(key, chan) % SETS;
      tag = key;
    end else begin
      set_idx = key % SETS;
      tag = key / SETS;
    end
    base = set_idx * WAYS;
    for (int i = 0; i < WAYS; i++)
      if (way_valid[base+i] && way_tag[base+i] == tag) begin
        age_set(base, i);
        return 1'b0;
      end
    have_free = 1'b0;
    victim = 0;
    for (int i = 0; i < WAYS; i++)
      if (!have_free && !way_valid[base+i]) begin
        victim = i;
        have_free = 1'b1;
      end
    if (!have_free) victim = (use_lru || lru_step) ? oldest_way(base) : coldest_way(base);
    way_tag[base+victim] = tag;
    way_valid[base+victim] = 1'b1;
    way_chan[base+victim] = chan;
    age_set(base, victim);
    return 1'b1;
  endfunction

  function automatic void open_step(logic [15:0] t);
    int next_t;
    if (step_started && t == cur_step) return;
    next_t = step_started ? int'(cur_step) + 1 : 1;
    if (!step_started && t == 0) begin
      // spikes so far already count toward step 0
    end else if (int'(t) == next_t) begin
      for (int c = 0; c < CHANNELS; c++) begin
        spikes_prev[c] = spikes_now[c];
        spikes_now[c] = '0;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        spikes_prev[c] = '0;
        spikes_now[c] = '0;
      end
    end
    lru_step = (t == 0);
    cur_step = t;
    step_started = 1'b1;
  endfunction

  function automatic void predict_outcome(request_t r);
    outcome_t o;
    bit use_lru, miss;
    int pf_n, pf_m;
    case (r.kind)
      KIND_SPIKE: begin
        if (r.channel < CHANNELS && spikes_now[r.channel] != SCORE_MAX)
          spikes_now[r.channel]++;
      end
      KIND_STEP: open_step(r.step);
      KIND_ACCESS: begin
        use_lru = r.force_lru || m_lru_policy;
        miss = lookup_line(r.tile, r.channel, r.kernel_row, r.kernel_col, use_lru);
        if (!step_started) begin
          cur_step = '0;
          step_started = 1'b1;
        end
        pf_n = 0;
        pf_m = 0;
        if (miss) begin
          for (int d = 1; d <= m_pf_depth; d++) begin
            if (int'(r.channel) + d > 65535) break;
            pf_n++;
            if (lookup_line(r.tile, r.channel + d[15:0], r.kernel_row, r.kernel_col, use_lru))
              pf_m++;
          end
        end
        o.line_miss = miss;
        o.line_cycles = miss ? m_miss_cyc : {2'b00, m_hit_cyc};
        o.prefetch_count = pf_n[2:0];
        o.prefetch_fills = pf_m[2:0];
        expected_q = {expected_q, o};
      end
      default: ;  // unused kind: dropped
    endcase
  endfunction

  function automatic void model_reset();
    m_lru_policy = 1'b0;
    m_hashed = 1'b1;
    m_pf_depth = 3'd0;
    m_hit_cyc = 8'd1;
    m_miss_cyc = 10'd20;
    for (int i = 0; i < SETS*WAYS; i++) begin
      way_tag[i] = '0;
      way_valid[i] = 1'b0;
      way_age[i] = '0;
      way_chan[i] = '0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      spikes_now[c] = '0;
      spikes_prev[c] = '0;
    end
    cur_step = '0;
    step_started = 1'b0;
    lru_step = 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Request side
  // -------------------------------------------------------------------------
  initial begin
    req.valid = 1'b0;
    req.kind = KIND_ACCESS;
    req.tile = '0;
    req.channel = '0;
    req.kernel_row = '0;
    req.kernel_col = '0;
    req.step = '0;
    req.force_lru = 1'b0;
  end

  // Hold the request until accepted, then update the model and drop valid.
  task automatic send_request(request_t r);
    if (!quiet && $urandom_range(7) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(7, 1)) @(negedge clk);
    end
    req.kind = r.kind;
    req.tile = r.tile;
    req.channel = r.channel;
    req.kernel_row = r.kernel_row;
    req.kernel_col = r.kernel_col;
    req.step = r.step;
    req.force_lru = r.force_lru;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    predict_outcome(r);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  function automatic request_t make_request(logic [1:0] kind, logic [23:0] tile,
      logic [15:0] chan, logic [11:0] kh, logic [11:0] kw, logic [15:0] t, logic f);
    request_t r;
    r.kind = kind; r.tile = tile; r.channel = chan;
    r.kernel_row = kh; r.kernel_col = kw; r.step = t; r.force_lru = f;
    return r;
  endfunction

  // Wait until every outcome is back, then let a pending step sweep finish.
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_LRU_MODE:    m_lru_policy = val[0];
      CFG_HASHED_MAP:  m_hashed = val[0];
      CFG_PF_DEPTH:    m_pf_depth = val[2:0];
      CFG_HIT_CYCLES:  m_hit_cyc = val[7:0];
      CFG_MISS_CYCLES: m_miss_cyc = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic lru, logic hashed, logic [2:0] depth,
                           logic [7:0] hit, logic [9:0] miss);
    drain();
    write_reg(CFG_LRU_MODE, {9'd0, lru});
    write_reg(CFG_HASHED_MAP, {9'd0, hashed});
    write_reg(CFG_PF_DEPTH, {7'd0, depth});
    write_reg(CFG_HIT_CYCLES, {2'd0, hit});
    write_reg(CFG_MISS_CYCLES, miss);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Corner cases under reset settings, then with deep prefetch at the top channel.
  task automatic test_corner_cases();
    send_request(make_request(KIND_SPIKE, 0, 16'd5, 0, 0, 0, 0));         // spike before any step
    send_request(make_request(KIND_ACCESS, 0, 16'd5, 0, 0, 0, 0));        // access before any step
    send_request(make_request(KIND_ACCESS, 0, 16'd5, 0, 0, 0, 0));        // plain hit
    send_request(make_request(KIND_STEP, 0, 0, 0, 0, 16'd0, 0));          // repeated step 0
    send_request(make_request(KIND_STEP, 0, 0, 0, 0, 16'd1, 0));          // next step
    send_request(make_request(KIND_STEP, 0, 0, 0, 0, 16'd1, 0));          // repeat: no effect
    send_request(make_request(KIND_SPIKE, 0, 16'd2000, 0, 0, 0, 0));      // channel out of range
    send_request(make_request(KIND_SPIKE, 0, 16'hFFFF, 0, 0, 0, 1));
    send_request(make_request(KIND_UNUSED, '1, '1, '1, '1, '1, 1));       // dropped
    send_request(make_request(KIND_STEP, 0, 0, 0, 0, 16'hFFFF, 0));       // jumped step
    send_request(make_request(KIND_STEP, 0, 0, 0, 0, 16'd3, 0));          // backward step
    send_request(make_request(KIND_ACCESS, '1, '1, '1, '1, 0, 1));        // all-ones line
    send_request(make_request(KIND_ACCESS, 0, 0, 0, 0, 0, 0));            // all-zeros line
    configure(1'b0, 1'b0, 3'd7, 8'd255, 10'd1023);
    send_request(make_request(KIND_ACCESS, 24'd9, 16'hFFFE, 12'd7, 12'd7, 0, 0)); // prefetch at top
    send_request(make_request(KIND_ACCESS, 24'd9, 16'hFFF0, 12'd7, 12'd7, 0, 0)); // full prefetch
    send_request(make_request(KIND_ACCESS, 24'd9, 16'hFFF3, 12'd7, 12'd7, 0, 0)); // prefetched: hit
    // fill one modulo set past capacity to force victim selection
    for (int i = 0; i < WAYS + 2; i++)
      send_request(make_request(KIND_ACCESS, 24'(i + 100), 16'd1, 0, 12'd3, 0, i[0]));
  endtask

  // Mostly well-formed traffic on a small working set so sets fill and
  // scores matter; a share of full-range noise.
  function automatic request_t random_request();
    request_t r;
    int pick;
    r.tile = 24'($urandom_range(7));
    r.channel = 16'($urandom_range(15));
    r.kernel_row = 12'($urandom_range(1));
    r.kernel_col = 12'($urandom_range(3));
    r.step = 16'($urandom);
    r.force_lru = ($urandom_range(4) == 0);
    pick = $urandom_range(99);
    if (pick < 60) r.kind = KIND_ACCESS;
    else if (pick < 80) r.kind = KIND_SPIKE;
    else if (pick < 92) begin
      r.kind = KIND_STEP;
      case ($urandom_range(9))
        0: r.step = cur_step;
        1: r.step = '0;
        2: ;  // random jump
        default: r.step = cur_step + 16'd1;
      endcase
    end else if (pick < 95) r.kind = KIND_UNUSED;
    else begin
      r.kind = $urandom_range(1) ? KIND_ACCESS : KIND_SPIKE;
      r.tile = 24'($urandom);
      r.channel = 16'($urandom);
      r.kernel_row = 12'($urandom);
      r.kernel_col = 12'($urandom);
      r.force_lru = 1'($urandom);
    end
    return r;
  endfunction

  task automatic run_random(int count);
    request_t r;
    int n;
    n = 0;
    while (n < count) begin
      r = random_request();
      send_request(r);
      if (r.kind != KIND_UNUSED) n++;
    end
  endtask

  task automatic test_lru_policy();
    configure(1'b1, 1'b0, 3'd7, 8'd255, 10'd1023);
    run_random(RANDOM_ITEMS / 5);
  endtask

  task automatic test_scoreboard_modulo();
    configure(1'b0, 1'b0, 3'd2, 8'd0, 10'd0);
    run_random(RANDOM_ITEMS / 5);
  endtask

  // switch mapping without a flush: stale tags stay as stored
  task automatic test_scoreboard_hashed();
    configure(1'b0, 1'b1, 3'($urandom_range(7)), 8'($urandom), 10'($urandom));
    run_random(RANDOM_ITEMS / 10);
    drain();  // hold new requests until every outcome is back
    run_random(RANDOM_ITEMS / 10);
  endtask

  task automatic test_mixed_settings();
    configure(1'($urandom), 1'($urandom), 3'($urandom_range(7)), 8'($urandom), 10'($urandom));
    run_random(RANDOM_ITEMS / 5);
  endtask

  task automatic test_full_rate();
    configure(1'b0, 1'b1, 3'd1, 8'd17, 10'd300);
    quiet = 1'b1;
    run_random(RANDOM_ITEMS / 5);
  endtask

  // -------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // -------------------------------------------------------------------------
  int hold_off = 0;

  initial rsp.ready = 1'b0;

  always @(negedge clk) begin
    if (quiet) begin
      rsp.ready = 1'b1;
    end else if (hold_off > 0) begin
      hold_off--;
      rsp.ready = 1'b0;
    end else if ($urandom_range(9) == 0) begin
      hold_off = $urandom_range(6);
      rsp.ready = 1'b0;
    end else begin
      rsp.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        fails++;
        if (mismatches++ < 10) $display("unexpected outcome: miss=%0b cycles=%0d", rsp.line_miss,
                                        rsp.line_cycles);
      end else begin
        want = expected_q.pop_front();
        if (rsp.line_miss !== want.line_miss || rsp.line_cycles !== want.line_cycles ||
            rsp.prefetch_count !== want.prefetch_count ||
            rsp.prefetch_fills !== want.prefetch_fills) begin
          fails++;
          if (mismatches++ < 10)
            $display("outcome mismatch: exp miss=%0b cyc=%0d pf=%0d pfm=%0d, got %0b %0d %0d %0d",
                     want.line_miss, want.line_cycles, want.prefetch_count,
                     want.prefetch_fills, rsp.line_miss, rsp.line_cycles,
                     rsp.prefetch_count, rsp.prefetch_fills);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: cycles without any handshake
  // -------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || expected_q.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("set_assoc_cache_scoreboard_evict_unit verification failed");
      $finish;
    end
  end

  // also catch a stuck request channel
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (req.valid && !req.ready) stuck_cycles <= stuck_cycles + 1;
    else stuck_cycles <= 0;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("set_assoc_cache_scoreboard_evict_unit verification failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_cases();
    test_lru_policy();
    test_scoreboard_modulo();
    test_scoreboard_hashed();
    test_mixed_settings();
    test_full_rate();
    drain();
    if (fails == 0)
      $display("set_assoc_cache_scoreboard_evict_unit verification clean");
    else
      $display("set_assoc_cache_scoreboard_evict_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/sace_pkg.sv
src/sace_in_if.sv
src/sace_out_if.sv
src/sace_hash.sv
src/sace_line_store.sv
src/sace_score_store.sv
src/set_assoc_cache_scoreboard_evict_unit.sv
bench/testbench.sv
